FILE: hw/rtl/acn_pkg.sv
package acn_pkg;

	// default axis count and addressing
	localparam int AXIS_COUNT_DEF = 128;

	// calibration reset bounds
	localparam logic signed [15:0] BOUND_HIGH_RST = 16'sd32767;
	localparam logic signed [15:0] BOUND_LOW_RST  = -16'sd32767;

	// fixed point scale of the normalized value
	localparam int NORM_SCALE = 1000;

	// quotient bits of the serial divider (|centered| * 1000 < 2**27)
	localparam int DIV_STEPS = 27;
	localparam int CNT_W     = $clog2(DIV_STEPS);

	// request codes
	localparam logic [1:0] REQ_EVENT    = 2'd0;
	localparam logic [1:0] REQ_SET_HIGH = 2'd1;
	localparam logic [1:0] REQ_SET_LOW  = 2'd2;

	// raw event type bits
	localparam logic [7:0] RAW_BUTTON = 8'h01;
	localparam logic [7:0] RAW_AXIS   = 8'h02;
	localparam logic [7:0] RAW_INIT   = 8'h80;

	// reported event kinds
	localparam logic [1:0] KIND_BUTTON  = 2'd0;
	localparam logic [1:0] KIND_AXIS    = 2'd1;
	localparam logic [1:0] KIND_UNKNOWN = 2'd2;

	typedef enum logic [1:0] {
		OP_SET_HIGH,
		OP_SET_LOW,
		OP_NORM,
		OP_PASS
	} acn_op_t;

	typedef enum logic [2:0] {
		B_IDLE,
		B_BOUND,
		B_MUL,
		B_DIV,
		B_SAT,
		B_EMIT
	} acn_bstate_t;

	typedef struct packed {
		logic [1:0]         req_type;
		logic [7:0]         raw_type;
		logic [7:0]         item_index;
		logic signed [15:0] sample_value;
		logic [31:0]        event_time;
	} acn_in_t;

	typedef struct packed {
		logic [1:0]         event_kind;
		logic [7:0]         out_index;
		logic signed [15:0] out_value;
		logic [31:0]        out_time;
		logic               zero_range_flag;
	} acn_out_t;

	// classified command between front and back
	typedef struct packed {
		acn_op_t            op;
		logic [1:0]         event_kind;
		logic [7:0]         item_index;
		logic signed [15:0] sample_value;
		logic [31:0]        event_time;
	} acn_cmd_t;

endpackage

FILE: hw/rtl/acn_fifo.sv
module acn_fifo #(
	parameter int W     = 8,
	parameter int DEPTH = 2
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] wdata,
	output logic         full,
	input  logic         pop,
	output logic [W-1:0] rdata,
	output logic         empty
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [W-1:0]  store_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          do_push;
	logic          do_pop;

	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = store_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			store_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("fifo count above depth");

	a_push_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(do_push && !do_pop) |=> (count_q == $past(count_q) + 1'b1))
		else $error("fifo count did not grow on push");

	a_pop_shrinks: assert property (@(posedge clk) disable iff (!arst_n)
		(do_pop && !do_push) |=> (count_q == $past(count_q) - 1'b1))
		else $error("fifo count did not shrink on pop");

endmodule

FILE: hw/rtl/acn_front.sv
module acn_front #(
	parameter int AXIS_COUNT = acn_pkg::AXIS_COUNT_DEF
) (
	input  acn_pkg::acn_in_t  req,
	input  logic              push,
	input  logic              q_full,
	output logic              q_push,
	output acn_pkg::acn_cmd_t cmd
);

	logic       idx_ok;
	logic       keep;
	logic [7:0] stripped;

	assign idx_ok   = ({1'b0, req.item_index} < 9'(AXIS_COUNT));
	assign stripped = req.raw_type & ~acn_pkg::RAW_INIT;

	// classify the request; out of range writes and unused codes are dropped
	always_comb begin
		keep   = 1'b0;
		cmd.op = acn_pkg::OP_PASS;
		case (req.req_type)
			acn_pkg::REQ_EVENT: begin
				keep   = 1'b1;
				cmd.op = (req.raw_type == acn_pkg::RAW_AXIS && idx_ok) ?
					acn_pkg::OP_NORM : acn_pkg::OP_PASS;
			end
			acn_pkg::REQ_SET_HIGH: begin
				keep   = idx_ok;
				cmd.op = acn_pkg::OP_SET_HIGH;
			end
			acn_pkg::REQ_SET_LOW: begin
				keep   = idx_ok;
				cmd.op = acn_pkg::OP_SET_LOW;
			end
			default: begin
				keep   = 1'b0;
				cmd.op = acn_pkg::OP_PASS;
			end
		endcase
	end

	always_comb begin
		if (stripped == acn_pkg::RAW_BUTTON) begin
			cmd.event_kind = acn_pkg::KIND_BUTTON;
		end else if (stripped == acn_pkg::RAW_AXIS) begin
			cmd.event_kind = acn_pkg::KIND_AXIS;
		end else begin
			cmd.event_kind = acn_pkg::KIND_UNKNOWN;
		end
	end

	assign cmd.item_index   = req.item_index;
	assign cmd.sample_value = req.sample_value;
	assign cmd.event_time   = req.event_time;
	assign q_push           = push && !q_full && keep;

endmodule

FILE: hw/rtl/acn_back.sv
module acn_back #(
	parameter int AXIS_COUNT = acn_pkg::AXIS_COUNT_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  acn_pkg::acn_cmd_t head,
	input  logic              cmd_empty,
	output logic              cmd_pop,
	input  logic              res_full,
	output logic              res_push,
	output acn_pkg::acn_out_t res
);

	localparam int AW = (AXIS_COUNT > 1) ? $clog2(AXIS_COUNT) : 1;
	localparam int QW = acn_pkg::DIV_STEPS;
	localparam int CW = acn_pkg::CNT_W;

	acn_pkg::acn_bstate_t state_q, state_nx;

	// bound memories with per-entry written flags
	logic signed [15:0]  hi_mem [AXIS_COUNT];
	logic signed [15:0]  lo_mem [AXIS_COUNT];
	logic [AXIS_COUNT-1:0] hi_vld_q;
	logic [AXIS_COUNT-1:0] lo_vld_q;
	logic signed [15:0]  hi_rd_q;
	logic signed [15:0]  lo_rd_q;
	logic                hi_vld_rd_q;
	logic                lo_vld_rd_q;

	logic                hi_we;
	logic                lo_we;
	logic                rd_en;
	logic [AW-1:0]       rd_addr;
	logic [AW-1:0]       wr_addr;
	logic signed [15:0]  hi_wdata;
	logic signed [15:0]  lo_wdata;

	acn_pkg::acn_cmd_t   cmd_q;
	logic signed [15:0]  value_q;
	logic                flag_q;
	logic signed [15:0]  half_q;
	logic signed [17:0]  cent_q;
	logic                neg_q;
	logic [14:0]         dmag_q;
	logic [15:0]         rem_q;
	logic [QW-1:0]       quo_q;
	logic [CW-1:0]       cnt_q;

	logic signed [15:0]  samp;
	logic signed [15:0]  hi_eff;
	logic signed [15:0]  lo_eff;
	logic signed [15:0]  hi_n;
	logic signed [15:0]  lo_n;
	logic signed [16:0]  diff;
	logic signed [16:0]  diff_adj;
	logic signed [15:0]  half;
	logic signed [17:0]  cent;
	logic signed [17:0]  cent_neg;
	logic [16:0]         cent_mag;
	logic signed [15:0]  half_neg;
	logic [15:0]         rem_sh;
	logic                ge;
	logic [15:0]         rem_nx;
	logic signed [15:0]  sat_val;

	// bounds widened by the sample
	assign samp     = cmd_q.sample_value;
	assign hi_eff   = hi_vld_rd_q ? hi_rd_q : acn_pkg::BOUND_HIGH_RST;
	assign lo_eff   = lo_vld_rd_q ? lo_rd_q : acn_pkg::BOUND_LOW_RST;
	assign lo_n     = (samp < lo_eff) ? samp : lo_eff;
	assign hi_n     = (samp > hi_eff) ? samp : hi_eff;
	// half range truncated toward zero
	assign diff     = {hi_n[15], hi_n} - {lo_n[15], lo_n};
	assign diff_adj = diff + {16'd0, diff[16]};
	assign half     = diff_adj[16:1];
	assign cent     = {{2{samp[15]}}, samp} - {{2{lo_n[15]}}, lo_n} - {{2{half[15]}}, half};

	assign cent_neg = -cent_q;
	assign cent_mag = cent_q[17] ? cent_neg[16:0] : cent_q[16:0];
	assign half_neg = -half_q;

	// restoring divider step, one quotient bit per cycle
	assign rem_sh = {rem_q[14:0], quo_q[QW-1]};
	assign ge     = (rem_sh >= {1'b0, dmag_q});
	assign rem_nx = ge ? rem_sh - {1'b0, dmag_q} : rem_sh;

	always_comb begin
		if (!neg_q) begin
			sat_val = (quo_q > QW'(32767)) ? 16'sh7fff : quo_q[15:0];
		end else begin
			sat_val = (quo_q > QW'(32768)) ? 16'sh8000 : 16'(16'd0 - quo_q[15:0]);
		end
	end

	assign rd_addr  = head.item_index[AW-1:0];
	assign wr_addr  = (state_q == acn_pkg::B_BOUND) ? cmd_q.item_index[AW-1:0] :
		head.item_index[AW-1:0];
	assign hi_wdata = (state_q == acn_pkg::B_BOUND) ? hi_n : head.sample_value;
	assign lo_wdata = (state_q == acn_pkg::B_BOUND) ? lo_n : head.sample_value;

	always_comb begin
		state_nx = state_q;
		case (state_q)
			acn_pkg::B_IDLE: begin
				if (!cmd_empty) begin
					case (head.op)
						acn_pkg::OP_NORM: state_nx = acn_pkg::B_BOUND;
						acn_pkg::OP_PASS: state_nx = acn_pkg::B_EMIT;
						default:          state_nx = acn_pkg::B_IDLE;
					endcase
				end
			end
			acn_pkg::B_BOUND: state_nx = (half == '0) ? acn_pkg::B_EMIT : acn_pkg::B_MUL;
			acn_pkg::B_MUL:   state_nx = acn_pkg::B_DIV;
			acn_pkg::B_DIV:   state_nx = (cnt_q == '0) ? acn_pkg::B_SAT : acn_pkg::B_DIV;
			acn_pkg::B_SAT:   state_nx = acn_pkg::B_EMIT;
			acn_pkg::B_EMIT:  state_nx = res_full ? acn_pkg::B_EMIT : acn_pkg::B_IDLE;
			default:          state_nx = acn_pkg::B_IDLE;
		endcase
	end

	always_comb begin
		cmd_pop  = 1'b0;
		hi_we    = 1'b0;
		lo_we    = 1'b0;
		rd_en    = 1'b0;
		res_push = 1'b0;
		case (state_q)
			acn_pkg::B_IDLE: begin
				cmd_pop = !cmd_empty;
				if (!cmd_empty) begin
					hi_we = (head.op == acn_pkg::OP_SET_HIGH);
					lo_we = (head.op == acn_pkg::OP_SET_LOW);
					rd_en = (head.op == acn_pkg::OP_NORM);
				end
			end
			acn_pkg::B_BOUND: begin
				hi_we = 1'b1;
				lo_we = 1'b1;
			end
			acn_pkg::B_EMIT: res_push = !res_full;
			default: begin
				cmd_pop = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= acn_pkg::B_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_nx;
			if (state_q == acn_pkg::B_MUL) begin
				cnt_q <= CW'(QW - 1);
			end else if (state_q == acn_pkg::B_DIV && cnt_q != '0) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	// bound memories
	always_ff @(posedge clk) begin
		if (hi_we) begin
			hi_mem[wr_addr] <= hi_wdata;
		end
		if (lo_we) begin
			lo_mem[wr_addr] <= lo_wdata;
		end
		if (rd_en) begin
			hi_rd_q <= hi_mem[rd_addr];
			lo_rd_q <= lo_mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hi_vld_q    <= '0;
			lo_vld_q    <= '0;
			hi_vld_rd_q <= 1'b0;
			lo_vld_rd_q <= 1'b0;
		end else begin
			if (hi_we) begin
				hi_vld_q[wr_addr] <= 1'b1;
			end
			if (lo_we) begin
				lo_vld_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				hi_vld_rd_q <= hi_vld_q[rd_addr];
				lo_vld_rd_q <= lo_vld_q[rd_addr];
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		case (state_q)
			acn_pkg::B_IDLE: begin
				if (!cmd_empty) begin
					cmd_q   <= head;
					value_q <= head.sample_value;
					flag_q  <= 1'b0;
				end
			end
			acn_pkg::B_BOUND: begin
				half_q <= half;
				cent_q <= cent;
				if (half == '0) begin
					value_q <= '0;
					flag_q  <= 1'b1;
				end
			end
			acn_pkg::B_MUL: begin
				quo_q  <= {{(QW - 17){1'b0}}, cent_mag} * QW'(acn_pkg::NORM_SCALE);
				rem_q  <= '0;
				dmag_q <= half_q[15] ? half_neg[14:0] : half_q[14:0];
				neg_q  <= cent_q[17] ^ half_q[15];
			end
			acn_pkg::B_DIV: begin
				rem_q <= rem_nx;
				quo_q <= {quo_q[QW-2:0], ge};
			end
			acn_pkg::B_SAT: value_q <= sat_val;
			default: begin
				value_q <= value_q;
			end
		endcase
	end

	assign res.event_kind      = cmd_q.event_kind;
	assign res.out_index       = cmd_q.item_index;
	assign res.out_value       = value_q;
	assign res.out_time        = cmd_q.event_time;
	assign res.zero_range_flag = flag_q;

	a_div_runs: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == acn_pkg::B_DIV && cnt_q != '0) |=> (state_q == acn_pkg::B_DIV))
		else $error("divider left before all quotient bits");

	a_zero_flag: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == acn_pkg::B_EMIT && flag_q) |-> (value_q == '0))
		else $error("zero range result not zero");

	a_dual_write: assert property (@(posedge clk) disable iff (!arst_n)
		(hi_we && lo_we) |-> (state_q == acn_pkg::B_BOUND))
		else $error("both bounds written outside write-back");

	a_pop_safe: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_pop |-> (!cmd_empty && state_q == acn_pkg::B_IDLE))
		else $error("command pop while busy or empty");

endmodule

FILE: hw/rtl/axis_autocalibrate_normalize.sv
// a pass-through event goes through the command queue, the back and the result queue
// an axis event goes through the command queue, the back's bound read and write-back,
//   multiply, 27-step serial divider, saturate, then the result queue (zero half range
//   skips multiply, divider and saturate); calibration writes are done as they are popped
// the back takes no new command while an axis event is in the bit-serial divider
// reset: arst_n clears both queues and the bound flags; unwritten bounds read as +/-32767
module axis_autocalibrate_normalize #(
	parameter int AXIS_COUNT = acn_pkg::AXIS_COUNT_DEF,
	parameter int CMD_DEPTH  = 2,
	parameter int RES_DEPTH  = 2
) (
	input  logic              clk,
	input  logic              arst_n,
	// request side
	input  logic              push,
	output logic              full,
	input  acn_pkg::acn_in_t  req,
	// result side
	output logic              empty,
	input  logic              pop,
	output acn_pkg::acn_out_t res
);

	localparam int CMDW = $bits(acn_pkg::acn_cmd_t);
	localparam int RESW = $bits(acn_pkg::acn_out_t);

	// front to back command queue
	acn_pkg::acn_cmd_t cmd_in;
	acn_pkg::acn_cmd_t cmd_head;
	logic [CMDW-1:0]   cmd_head_vec;
	logic              cmd_push;
	logic              cmd_full;
	logic              cmd_pop;
	logic              cmd_empty;

	// back to result queue
	acn_pkg::acn_out_t back_res;
	logic [RESW-1:0]   res_vec;
	logic              res_push;
	logic              res_full;

	// a request is taken whenever the command queue has room; dropped requests too
	assign full = cmd_full;

	// front: classify each request into a command
	acn_front #(
		.AXIS_COUNT(AXIS_COUNT)
	) u_front (
		.req    (req),
		.push   (push),
		.q_full (cmd_full),
		.q_push (cmd_push),
		.cmd    (cmd_in)
	);

	// short queue so the front keeps accepting while the back divides
	acn_fifo #(
		.W     (CMDW),
		.DEPTH (CMD_DEPTH)
	) u_cmd_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (cmd_push),
		.wdata  (cmd_in),
		.full   (cmd_full),
		.pop    (cmd_pop),
		.rdata  (cmd_head_vec),
		.empty  (cmd_empty)
	);

	assign cmd_head = acn_pkg::acn_cmd_t'(cmd_head_vec);

	// back: bound tracking, normalization and pass-through
	acn_back #(
		.AXIS_COUNT(AXIS_COUNT)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (cmd_head),
		.cmd_empty (cmd_empty),
		.cmd_pop   (cmd_pop),
		.res_full  (res_full),
		.res_push  (res_push),
		.res       (back_res)
	);

	// result queue parts the back from the consumer
	acn_fifo #(
		.W     (RESW),
		.DEPTH (RES_DEPTH)
	) u_res_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (res_push),
		.wdata  (back_res),
		.full   (res_full),
		.pop    (pop),
		.rdata  (res_vec),
		.empty  (empty)
	);

	assign res = acn_pkg::acn_out_t'(res_vec);

endmodule

FILE: tb/sv/acn_norm_check.sv
module acn_norm_check #(
	parameter int AXIS_COUNT = acn_pkg::AXIS_COUNT_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  logic              full,
	input  acn_pkg::acn_in_t  req,
	input  logic              empty,
	input  logic              pop,
	input  acn_pkg::acn_out_t res,
	output int unsigned       mismatches,
	output int unsigned       outstanding
);
	timeunit 1ns;
	timeprecision 1ps;
	import acn_pkg::*;

	// shadow calibration bounds
	logic signed [15:0] high_bound [AXIS_COUNT];
	logic signed [15:0] low_bound  [AXIS_COUNT];

	acn_out_t    norm_q [$];
	int unsigned errors = 0;

	assign mismatches = errors;

	// applies one request to the shadow bounds, returns 1 when it yields a result
	function automatic bit normalize_event(input acn_in_t r, output acn_out_t o);
		logic signed [15:0] lo;
		logic signed [15:0] hi;
		logic [7:0]         bare;
		int                 half_span;
		longint             centered;
		longint             scaled;
		o.out_index       = r.item_index;
		o.out_value       = r.sample_value;
		o.out_time        = r.event_time;
		o.zero_range_flag = 1'b0;
		o.event_kind      = KIND_UNKNOWN;
		if (r.req_type == REQ_SET_HIGH || r.req_type == REQ_SET_LOW) begin
			if (int'(r.item_index) < AXIS_COUNT) begin
				if (r.req_type == REQ_SET_HIGH)
					high_bound[r.item_index] = r.sample_value;
				else
					low_bound[r.item_index] = r.sample_value;
			end
			return 1'b0;
		end
		if (r.req_type != REQ_EVENT)
			return 1'b0;
		if (r.raw_type == RAW_AXIS && int'(r.item_index) < AXIS_COUNT) begin
			lo = low_bound[r.item_index];
			hi = high_bound[r.item_index];
			if ($signed(r.sample_value) < lo)
				lo = r.sample_value;
			if ($signed(r.sample_value) > hi)
				hi = r.sample_value;
			low_bound[r.item_index]  = lo;
			high_bound[r.item_index] = hi;
			half_span = (int'(hi) - int'(lo)) / 2;
			if (half_span == 0) begin
				o.out_value       = '0;
				o.zero_range_flag = 1'b1;
			end else begin
				centered = longint'($signed(r.sample_value)) - (longint'(lo) + half_span);
				scaled   = (centered * NORM_SCALE) / half_span;
				if (scaled > 32767)
					scaled = 32767;
				else if (scaled < -32768)
					scaled = -32768;
				o.out_value = 16'(scaled);
			end
		end
		bare = r.raw_type & ~RAW_INIT;
		if (bare == RAW_BUTTON)
			o.event_kind = KIND_BUTTON;
		else if (bare == RAW_AXIS)
			o.event_kind = KIND_AXIS;
		return 1'b1;
	endfunction

	task automatic compare_field(input string name, input longint want, input longint got);
		if (want != got) begin
			$error("%s: expected %0d, actual %0d", name, want, got);
			errors++;
		end
	endtask

	always @(posedge clk) begin
		acn_out_t want;
		acn_out_t pred;
		if (!arst_n) begin
			foreach (high_bound[i]) begin
				high_bound[i] = BOUND_HIGH_RST;
				low_bound[i]  = BOUND_LOW_RST;
			end
			norm_q.delete();
			outstanding <= 0;
		end else begin
			// results leave before this edge's request can add one
			if (pop && !empty) begin
				if (norm_q.size() == 0) begin
					$error("result: expected none, actual index %0d value %0d",
						res.out_index, $signed(res.out_value));
					errors++;
				end else begin
					want = norm_q.pop_front();
					compare_field("event_kind", want.event_kind, res.event_kind);
					compare_field("out_index", want.out_index, res.out_index);
					compare_field("out_value", $signed(want.out_value), $signed(res.out_value));
					compare_field("out_time", want.out_time, res.out_time);
					compare_field("zero_range_flag", want.zero_range_flag,
						res.zero_range_flag);
				end
			end
			if (push && !full && normalize_event(req, pred))
				norm_q.push_back(pred);
			outstanding <= norm_q.size();
		end
	end

endmodule

FILE: tb/sv/tb_axis_autocalibrate_normalize.sv
module tb_axis_autocalibrate_normalize;
	timeunit 1ns;
	timeprecision 1ps;
	import acn_pkg::*;

	// request code the block must ignore
	localparam logic [1:0] REQ_NONE = 2'd3;
	// cycles without any handshake before the run is declared hung
	localparam int STALL_LIMIT = 4000;
	// settling time after the last result, longer than an axis event
	localparam int DRAIN_CYCLES = 64;

	logic        clk    = 1'b0;
	logic        arst_n = 1'b0;
	logic        push   = 1'b0;
	logic        pop    = 1'b0;
	acn_in_t     req    = '0;
	logic        full;
	logic        empty;
	acn_out_t    res;
	int unsigned mismatches;
	int unsigned outstanding;
	int          idle_pct = 26;
	int          quiet_cycles = 0;

	always #2 clk = ~clk;

	axis_autocalibrate_normalize dut (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (full),
		.req    (req),
		.empty  (empty),
		.pop    (pop),
		.res    (res)
	);

	acn_norm_check u_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.full        (full),
		.req         (req),
		.empty       (empty),
		.pop         (pop),
		.res         (res),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	// result side: random stalls, none while idle_pct is zero
	always @(posedge clk) begin
		if (!arst_n)
			pop <= 1'b0;
		else
			pop <= ($urandom_range(99) >= idle_pct);
	end

	// watchdog: any handshake on either side restarts the count
	always @(posedge clk) begin
		if (!arst_n || (push && !full) || (pop && !empty)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("FAIL axis_autocalibrate_normalize");
				$finish;
			end
		end
	end

	// mostly small magnitudes so writes give narrow ranges, plus full-scale and extremes
	function automatic logic signed [15:0] draw_sample();
		int v;
		case ($urandom_range(3))
			0: v = int'($urandom_range(128)) - 64;
			1: v = $urandom;
			2: v = $urandom_range(1) ? 32767 : -32768;
			default: v = int'($urandom_range(2000)) - 1000;
		endcase
		return 16'(v);
	endfunction

	// hold the request until it is taken, then maybe leave a gap
	task automatic issue(input logic [1:0] code, input logic [7:0] raw, input logic [7:0] idx,
			input logic signed [15:0] sample, input logic [31:0] stamp);
		push             <= 1'b1;
		req.req_type     <= code;
		req.raw_type     <= raw;
		req.item_index   <= idx;
		req.sample_value <= sample;
		req.event_time   <= stamp;
		do @(posedge clk); while (full);
		// each idle cycle is drawn on its own
		while ($urandom_range(99) < idle_pct) begin
			push <= 1'b0;
			@(posedge clk);
		end
	endtask

	// stop sending until every predicted result has been popped
	task automatic drain();
		push <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
	endtask

	initial begin
		int               pick;
		logic [7:0]       axis_sel;
		logic signed [15:0] pin;
		logic [31:0]      stamp;

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: reset bounds, full scale and widening on axis 0
		issue(REQ_EVENT, RAW_AXIS, 8'd0, 16'sd0, 32'h0000_0000);
		issue(REQ_EVENT, RAW_AXIS, 8'd0, 16'sd32767, 32'hFFFF_FFFF);
		issue(REQ_EVENT, RAW_AXIS, 8'd0, -16'sd32768, 32'h1234_5678);
		issue(REQ_EVENT, RAW_AXIS, 8'd0, -16'sd32767, 32'h8000_0000);
		// buttons and init-flagged events pass through
		issue(REQ_EVENT, RAW_BUTTON, 8'd5, 16'sd1, 32'h0000_0001);
		issue(REQ_EVENT, RAW_BUTTON | RAW_INIT, 8'd255, -16'sd1, 32'h5555_5555);
		issue(REQ_EVENT, RAW_AXIS | RAW_INIT, 8'd1, 16'sd1234, 32'hAAAA_AAAA);
		// unknown raw types
		issue(REQ_EVENT, 8'h00, 8'd2, 16'sd77, 32'h0F0F_0F0F);
		issue(REQ_EVENT, 8'h7F, 8'd3, -16'sd77, 32'hF0F0_F0F0);
		issue(REQ_EVENT, 8'hFF, 8'd4, 16'sd32767, 32'h0000_FFFF);
		// axis numbers at and past the table end
		issue(REQ_EVENT, RAW_AXIS, 8'd127, 16'sd500, 32'hFFFF_0000);
		issue(REQ_EVENT, RAW_AXIS, 8'd128, 16'sd500, 32'h0000_0002);
		issue(REQ_EVENT, RAW_AXIS, 8'd255, -16'sd500, 32'h0000_0003);
		// zero half range: both bounds pinned to the sample
		issue(REQ_SET_HIGH, 8'h00, 8'd3, 16'sd10, 32'h0000_0004);
		issue(REQ_SET_LOW, 8'hFF, 8'd3, 16'sd10, 32'h0000_0005);
		issue(REQ_EVENT, RAW_AXIS, 8'd3, 16'sd10, 32'h0000_0006);
		// inverted bounds
		issue(REQ_SET_LOW, 8'h02, 8'd4, 16'sd100, 32'h0000_0007);
		issue(REQ_SET_HIGH, 8'h02, 8'd4, -16'sd100, 32'h0000_0008);
		issue(REQ_EVENT, RAW_AXIS, 8'd4, 16'sd50, 32'h0000_0009);
		// narrow range, both ends
		issue(REQ_SET_HIGH, 8'h00, 8'd6, 16'sd4, 32'h0000_000A);
		issue(REQ_SET_LOW, 8'h00, 8'd6, 16'sd0, 32'h0000_000B);
		issue(REQ_EVENT, RAW_AXIS, 8'd6, 16'sd4, 32'h0000_000C);
		issue(REQ_EVENT, RAW_AXIS, 8'd6, 16'sd0, 32'h0000_000D);
		// ignored: out-of-range write and the unused code
		issue(REQ_SET_HIGH, 8'h00, 8'd200, 16'sd1, 32'h0000_000E);
		issue(REQ_NONE, RAW_AXIS, 8'd6, 16'sd3, 32'h0000_000F);
		drain();

		// random: mostly axis traffic on a few axes with bound rewrites in between
		for (int n = 0; n < 900; n++) begin
			// a calm stretch where the bench adds no idle gaps or stalls on either side
			idle_pct <= (n >= 300 && n < 420) ? 0 : 26;
			if (n == 600)
				drain();
			pick     = $urandom_range(99);
			axis_sel = ($urandom_range(3) != 0) ? 8'($urandom_range(7))
				: 8'($urandom_range(127));
			stamp    = $urandom;
			if (pick < 5) begin
				// pin both bounds then hit them: zero or unit range
				pin = draw_sample();
				issue(REQ_SET_HIGH, 8'($urandom), axis_sel, pin, stamp);
				issue(REQ_SET_LOW, 8'($urandom), axis_sel, pin - 16'(pick[0]), $urandom);
				issue(REQ_EVENT, RAW_AXIS, axis_sel, pin, $urandom);
			end else if (pick < 50) begin
				issue(REQ_EVENT, RAW_AXIS, axis_sel, draw_sample(), stamp);
			end else if (pick < 63) begin
				issue(pick[0] ? REQ_SET_HIGH : REQ_SET_LOW, 8'($urandom), axis_sel,
					draw_sample(), stamp);
			end else if (pick < 75) begin
				issue(REQ_EVENT, pick[1] ? (RAW_BUTTON | RAW_INIT) : RAW_BUTTON,
					8'($urandom), draw_sample(), stamp);
			end else if (pick < 85) begin
				issue(REQ_EVENT, pick[0] ? (RAW_AXIS | RAW_INIT) : 8'($urandom),
					axis_sel, draw_sample(), stamp);
			end else if (pick < 93) begin
				// axis numbers past the table: events pass, writes are dropped
				issue(pick[0] ? REQ_EVENT : (pick[1] ? REQ_SET_HIGH : REQ_SET_LOW),
					RAW_AXIS, 8'($urandom_range(255, 128)), draw_sample(), stamp);
			end else begin
				issue(REQ_NONE, 8'($urandom), 8'($urandom), draw_sample(), stamp);
			end
		end

		drain();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("PASS axis_autocalibrate_normalize");
		else
			$display("FAIL axis_autocalibrate_normalize");
		$finish;
	end

endmodule

FILE: filelist.f
hw/rtl/acn_pkg.sv
hw/rtl/acn_fifo.sv
hw/rtl/acn_front.sv
hw/rtl/acn_back.sv
hw/rtl/axis_autocalibrate_normalize.sv
tb/sv/acn_norm_check.sv
tb/sv/tb_axis_autocalibrate_normalize.sv
